// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/pqus_pkg.sv =====
// Package with operation and status codes and control structs for the pending queue unit.
package pqus_pkg;

    // Operation codes carried by the operation field.
    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_COMPLETE = 2'd1,
        OP_UNDO     = 2'd2
    } op_t;

    // Status codes returned with every result word.
    typedef enum logic [2:0] {
        ST_OK              = 3'd0,
        ST_PENDING_EMPTY   = 3'd1,
        ST_COMPLETED_EMPTY = 3'd2,
        ST_PENDING_FULL    = 3'd3,
        ST_COMPLETED_FULL  = 3'd4
    } status_t;

    // Command to a whole chain of cells.
    typedef struct packed {
        logic push;   // shift toward the far end, insert at cell zero
        logic pop;    // shift toward cell zero
        logic write;  // write one cell chosen by index
    } chain_cmd_t;

    // Control of a single cell.
    typedef struct packed {
        logic push;   // take the value of the lower neighbor
        logic pop;    // take the value of the upper neighbor
        logic load;   // take the write data
    } cell_ctrl_t;

endpackage

// ===== sv/pqus_cell.sv =====
// One storage cell of a handle chain, loading from either neighbor or from write data.
module pqus_cell #(
    parameter int WIDTH = 16
) (
    input  logic                   clk,
    input  pqus_pkg::cell_ctrl_t   ctrl,
    input  logic [WIDTH-1:0]       lower,
    input  logic [WIDTH-1:0]       upper,
    input  logic [WIDTH-1:0]       wdata,
    output logic [WIDTH-1:0]       q
);

    logic [WIDTH-1:0] data_reg;
    logic [WIDTH-1:0] data_next;

    // Select the new cell contents; shifts take priority over a local write.
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.push)
        begin
            data_next = lower;
        end
        else if (ctrl.pop)
        begin
            data_next = upper;
        end
        else if (ctrl.load)
        begin
            data_next = wdata;
        end
    end

    // Payload storage needs no reset.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

// ===== sv/pqus_chain.sv =====
// A row of handle cells with cell zero at the front, shifting in either direction.
module pqus_chain #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 16
) (
    input  logic                       clk,
    input  pqus_pkg::chain_cmd_t       cmd,
    input  logic [$clog2(DEPTH)-1:0]   write_index,
    input  logic [WIDTH-1:0]           push_data,
    input  logic [WIDTH-1:0]           write_data,
    output logic [WIDTH-1:0]           head
);

    localparam int IW = $clog2(DEPTH);

    logic [WIDTH-1:0] cell_q [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            pqus_pkg::cell_ctrl_t ctrl;
            logic [WIDTH-1:0]     lower;
            logic [WIDTH-1:0]     upper;

            // Each cell decodes the chain command and its own write match.
            assign ctrl.push = cmd.push;
            assign ctrl.pop  = cmd.pop;
            assign ctrl.load = cmd.write && (write_index == IW'(i));

            // Cell zero takes the inserted word; the last cell keeps its own on a pop.
            if (i == 0)
            begin : g_first
                assign lower = push_data;
            end
            else
            begin : g_inner_low
                assign lower = cell_q[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign upper = cell_q[i];
            end
            else
            begin : g_inner_high
                assign upper = cell_q[i+1];
            end

            pqus_cell #(
                .WIDTH (WIDTH)
            ) u_cell (
                .clk   (clk),
                .ctrl  (ctrl),
                .lower (lower),
                .upper (upper),
                .wdata (write_data),
                .q     (cell_q[i])
            );
        end
    endgenerate

    assign head = cell_q[0];

endmodule

// ===== sv/pending_queue_with_undo_stack_unit.sv =====
// Top level of the pending queue with completion undo stack.
//
// One operation is accepted in every clock cycle: busy never rises, and the result word
// appears with the done strobe in the cycle after start, for exactly one cycle, since the
// receiver cannot stall. The pending queue and the completed stack are each a row of
// cells with the front at cell zero, so add writes the cell at the fill count, complete
// and undo shift both rows by one cell in the same cycle, and the handle that they move is
// read from cell zero. The counts on the result ports are the fills after the operation.
module pending_queue_with_undo_stack_unit #(
    parameter int PENDING_DEPTH   = 256,
    parameter int COMPLETED_DEPTH = 256,
    parameter int HANDLE_WIDTH    = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           operation,
    input  logic [HANDLE_WIDTH-1:0]              task_handle,
    output logic                                 done,
    output logic [2:0]                           status,
    output logic [HANDLE_WIDTH-1:0]              moved_handle,
    output logic [$clog2(PENDING_DEPTH+1)-1:0]   pending_count,
    output logic [$clog2(COMPLETED_DEPTH+1)-1:0] completed_count
);

    localparam int PCW = $clog2(PENDING_DEPTH + 1);
    localparam int CCW = $clog2(COMPLETED_DEPTH + 1);
    localparam int PIW = $clog2(PENDING_DEPTH);
    localparam int CIW = $clog2(COMPLETED_DEPTH);

    logic                    done_reg;
    logic                    done_next;
    pqus_pkg::status_t       status_reg;
    pqus_pkg::status_t       status_next;
    logic [HANDLE_WIDTH-1:0] moved_reg;
    logic [HANDLE_WIDTH-1:0] moved_next;
    logic [PCW-1:0]          pfill_reg;
    logic [PCW-1:0]          pfill_next;
    logic [CCW-1:0]          cfill_reg;
    logic [CCW-1:0]          cfill_next;

    pqus_pkg::op_t           op;
    pqus_pkg::chain_cmd_t    pend_cmd;
    pqus_pkg::chain_cmd_t    comp_cmd;
    logic [HANDLE_WIDTH-1:0] pend_head;
    logic [HANDLE_WIDTH-1:0] comp_head;
    logic                    pend_full;
    logic                    pend_empty;
    logic                    comp_full;
    logic                    comp_empty;

    assign busy = 1'b0;
    assign op   = pqus_pkg::op_t'(operation);

    assign pend_full  = (pfill_reg == PCW'(PENDING_DEPTH));
    assign pend_empty = (pfill_reg == '0);
    assign comp_full  = (cfill_reg == CCW'(COMPLETED_DEPTH));
    assign comp_empty = (cfill_reg == '0);

    // Decode the operation against the fills and drive both chains.
    always_comb
    begin
        done_next   = start;
        status_next = pqus_pkg::ST_OK;
        moved_next  = '0;
        pfill_next  = pfill_reg;
        cfill_next  = cfill_reg;
        pend_cmd    = '0;
        comp_cmd    = '0;
        if (start)
        begin
            case (op)
                pqus_pkg::OP_ADD:
                begin
                    if (pend_full)
                    begin
                        status_next = pqus_pkg::ST_PENDING_FULL;
                    end
                    else
                    begin
                        pend_cmd.write = 1'b1;
                        pfill_next     = pfill_reg + PCW'(1);
                        moved_next     = task_handle;
                    end
                end
                pqus_pkg::OP_COMPLETE:
                begin
                    if (pend_empty)
                    begin
                        status_next = pqus_pkg::ST_PENDING_EMPTY;
                    end
                    else if (comp_full)
                    begin
                        status_next = pqus_pkg::ST_COMPLETED_FULL;
                    end
                    else
                    begin
                        pend_cmd.pop  = 1'b1;
                        comp_cmd.push = 1'b1;
                        pfill_next    = pfill_reg - PCW'(1);
                        cfill_next    = cfill_reg + CCW'(1);
                        moved_next    = pend_head;
                    end
                end
                pqus_pkg::OP_UNDO:
                begin
                    if (comp_empty)
                    begin
                        status_next = pqus_pkg::ST_COMPLETED_EMPTY;
                    end
                    else if (pend_full)
                    begin
                        status_next = pqus_pkg::ST_PENDING_FULL;
                    end
                    else
                    begin
                        comp_cmd.pop  = 1'b1;
                        pend_cmd.push = 1'b1;
                        pfill_next    = pfill_reg + PCW'(1);
                        cfill_next    = cfill_reg - CCW'(1);
                        moved_next    = comp_head;
                    end
                end
                default:
                begin
                    // The unused code leaves everything as it is.
                end
            endcase
        end
    end

    // Control state with asynchronous reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= 1'b0;
            pfill_reg <= '0;
            cfill_reg <= '0;
        end
        else
        begin
            done_reg  <= done_next;
            pfill_reg <= pfill_next;
            cfill_reg <= cfill_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        moved_reg  <= moved_next;
    end

    // Pending queue: cell zero is the head, add writes at the fill count.
    pqus_chain #(
        .DEPTH (PENDING_DEPTH),
        .WIDTH (HANDLE_WIDTH)
    ) u_pending (
        .clk         (clk),
        .cmd         (pend_cmd),
        .write_index (pfill_reg[PIW-1:0]),
        .push_data   (comp_head),
        .write_data  (task_handle),
        .head        (pend_head)
    );

    // Completed stack: cell zero is the top; it is never written by index.
    pqus_chain #(
        .DEPTH (COMPLETED_DEPTH),
        .WIDTH (HANDLE_WIDTH)
    ) u_completed (
        .clk         (clk),
        .cmd         (comp_cmd),
        .write_index ({CIW{1'b0}}),
        .push_data   (pend_head),
        .write_data  ({HANDLE_WIDTH{1'b0}}),
        .head        (comp_head)
    );

    assign done            = done_reg;
    assign status          = status_reg;
    assign moved_handle    = moved_reg;
    assign pending_count   = pfill_reg;
    assign completed_count = cfill_reg;

endmodule

// ===== sv/pqus_checker.sv =====
// Port-level checker for the pending queue unit and its bind to the top level.
`include "assert_macros.svh"

module pqus_checker #(
    parameter int PENDING_DEPTH   = 256,
    parameter int COMPLETED_DEPTH = 256,
    parameter int HANDLE_WIDTH    = 16
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 start,
    input logic                                 busy,
    input logic                                 done,
    input logic [2:0]                           status,
    input logic [HANDLE_WIDTH-1:0]              moved_handle,
    input logic [$clog2(PENDING_DEPTH+1)-1:0]   pending_count,
    input logic [$clog2(COMPLETED_DEPTH+1)-1:0] completed_count
);

    localparam int PCW = $clog2(PENDING_DEPTH + 1);
    localparam int CCW = $clog2(COMPLETED_DEPTH + 1);

    // Every accepted word yields exactly one result in the next cycle.
    `ASSERT_NEXT(a_result_follows, clk, rst_n, start && !busy, done)
    `ASSERT_NEXT(a_no_spurious_result, clk, rst_n, !(start && !busy), !done)

    // A failed operation moves no handle.
    `ASSERT_IMPLIES(a_error_zero_handle, clk, rst_n,
        done && (status != pqus_pkg::ST_OK), moved_handle == '0)

    // The counts never exceed the capacities.
    `ASSERT_IMPLIES(a_count_bounds, clk, rst_n, done,
        (pending_count <= PCW'(PENDING_DEPTH)) && (completed_count <= CCW'(COMPLETED_DEPTH)))

endmodule

bind pending_queue_with_undo_stack_unit pqus_checker #(
    .PENDING_DEPTH   (PENDING_DEPTH),
    .COMPLETED_DEPTH (COMPLETED_DEPTH),
    .HANDLE_WIDTH    (HANDLE_WIDTH)
) u_pqus_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .done            (done),
    .status          (status),
    .moved_handle    (moved_handle),
    .pending_count   (pending_count),
    .completed_count (completed_count)
);
